@@ hdl/assert_macros.svh @@
// assertion macros used by the decoder sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define DZ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dzvr assertion failed");
`define DZ_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("dzvr assertion failed");
`else
`define DZ_ASSERT(lbl, prop)
`define DZ_ASSERT_NEXT(lbl, cond, nxt)
`endif

`endif

@@ hdl/dzvr_pkg.sv @@
// shared types and constants of the varint record decoder
`timescale 1ns / 1ps

package dzvr_pkg;

    localparam int ACTIONS = 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  field_kind;
        logic [5:0]  action_index;
        logic [63:0] value;
        logic        record_last;
        logic        truncated;
        logic        stream_done;
    } t_out_beat;

    // one finished varint handed from the byte gatherer to the sequencer
    typedef struct packed {
        logic [63:0] value;
        logic        truncated;
        logic        last_byte;
    } t_varint;

    function automatic logic [63:0] unzigzag(input logic [63:0] e);
        return (e >> 1) ^ {64{e[0]}};
    endfunction

endpackage

@@ hdl/dzvr_gather.sv @@
// front end: gathers 7-bit groups of each varint, one byte per cycle while the queue is not full
`timescale 1ns / 1ps

module dzvr_gather (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dzvr_pkg::t_in_beat i_in_data,
    input  logic               i_full,
    output logic               o_push,
    output dzvr_pkg::t_varint  o_push_data
);
    import dzvr_pkg::*;

    // first group index whose payload bits fall wholly beyond bit 63
    localparam logic [3:0] GRP_STOP = 4'd10;

    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_grp, n_grp;
    logic [6:0]  w_shamt;
    logic [63:0] w_shifted;
    logic [63:0] w_merged;
    logic        w_accept;
    logic        w_ends;

    assign w_accept  = i_in_valid && !i_full;
    assign w_shamt   = 7'(r_grp) * 7'd7;
    assign w_shifted = (r_grp < GRP_STOP) ? ({57'd0, i_in_data.in_byte[6:0]} << w_shamt)
                                          : 64'd0;
    assign w_merged  = r_acc | w_shifted;
    assign w_ends    = !i_in_data.in_byte[7] || i_in_data.end_of_buffer;

    assign o_push                = w_accept && w_ends;
    assign o_push_data.value     = w_merged;
    assign o_push_data.truncated = i_in_data.in_byte[7];
    assign o_push_data.last_byte = i_in_data.end_of_buffer;

    always_comb begin
        n_acc = r_acc;
        n_grp = r_grp;
        if (w_accept) begin
            if (w_ends) begin
                n_acc = 64'd0;
                n_grp = 4'd0;
            end else begin
                n_acc = w_merged;
                if (r_grp < GRP_STOP) begin
                    n_grp = r_grp + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 64'd0;
            r_grp <= 4'd0;
        end else begin
            r_acc <= n_acc;
            r_grp <= n_grp;
        end
    end

endmodule

@@ hdl/dzvr_fifo.sv @@
// two-entry queue of finished varints between gatherer and sequencer
`timescale 1ns / 1ps

module dzvr_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dzvr_pkg::t_varint i_push_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output dzvr_pkg::t_varint o_data
);
    import dzvr_pkg::*;

    t_varint    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hdl/dzvr_seq.sv @@
// back end: record sequencer, delta keys, zigzag values and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dzvr_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dzvr_pkg::t_varint   i_data,
    output logic                o_pop,
    output logic                o_out_valid,
    output dzvr_pkg::t_out_beat o_out_data,
    input  logic                i_out_stall
);
    import dzvr_pkg::*;

    localparam logic [2:0] PH_COUNT    = 3'd0;
    localparam logic [2:0] PH_KEY      = 3'd1;
    localparam logic [2:0] PH_REGRET   = 3'd2;
    localparam logic [2:0] PH_STRATEGY = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;

    localparam logic [1:0] KIND_COUNT    = 2'd0;
    localparam logic [1:0] KIND_KEY      = 2'd1;
    localparam logic [1:0] KIND_REGRET   = 2'd2;
    localparam logic [1:0] KIND_STRATEGY = 2'd3;

    localparam logic [5:0] LAST_POS = 6'(ACTIONS - 1);

    logic [2:0]  r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_left, n_left;
    logic [63:0] r_prev_key, n_prev_key;
    t_out_beat   r_out, n_out;
    logic        r_out_valid, n_out_valid;
    logic        w_can_load;
    logic        w_active;
    logic [63:0] w_key_sum;

    assign w_can_load  = !r_out_valid || !i_out_stall;
    assign o_pop       = i_valid && w_can_load;
    // phase codes above the strategy phase all behave as done
    assign w_active    = o_pop && (r_phase < PH_DONE);
    assign w_key_sum   = r_prev_key + i_data.value;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_left     = r_left;
        n_prev_key = r_prev_key;
        n_out      = r_out;

        n_out_valid = w_can_load ? w_active : r_out_valid;

        if (w_active) begin
            n_out.field_kind   = KIND_COUNT;
            n_out.action_index = 6'd0;
            n_out.value        = i_data.value;
            n_out.record_last  = 1'b0;
            n_out.truncated    = i_data.truncated;
            n_out.stream_done  = 1'b0;

            unique case (r_phase)
                PH_COUNT: begin
                    n_left = i_data.value;
                    if (i_data.value == 64'd0) begin
                        n_out.stream_done = 1'b1;
                    end else begin
                        n_phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    n_out.field_kind = KIND_KEY;
                    n_out.value      = w_key_sum;
                    n_prev_key       = w_key_sum;
                    n_pos            = 6'd0;
                    n_phase          = PH_REGRET;
                end
                PH_REGRET: begin
                    n_out.field_kind   = KIND_REGRET;
                    n_out.action_index = r_pos;
                    n_out.value        = unzigzag(i_data.value);
                    if (r_pos >= LAST_POS) begin
                        n_pos   = 6'd0;
                        n_phase = PH_STRATEGY;
                    end else begin
                        n_pos = r_pos + 6'd1;
                    end
                end
                default: begin
                    n_out.field_kind   = KIND_STRATEGY;
                    n_out.action_index = r_pos;
                    n_out.value        = unzigzag(i_data.value);
                    if (r_pos >= LAST_POS) begin
                        n_pos             = 6'd0;
                        n_out.record_last = 1'b1;
                        n_left            = r_left - 64'd1;
                        if (r_left == 64'd1) begin
                            n_out.stream_done = 1'b1;
                        end else begin
                            n_phase = PH_KEY;
                        end
                    end else begin
                        n_pos = r_pos + 6'd1;
                    end
                end
            endcase

            // buffer end closes the value, the record and the stream
            if (i_data.last_byte) begin
                n_out.stream_done = 1'b1;
                if (r_phase != PH_COUNT) begin
                    n_out.record_last = 1'b1;
                end
            end
            if (n_out.stream_done) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COUNT;
            r_pos       <= 6'd0;
            r_left      <= 64'd0;
            r_prev_key  <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_left      <= n_left;
            r_prev_key  <= n_prev_key;
            r_out_valid <= n_out_valid;
        end
    end

    `DZ_ASSERT(a_pos_range, r_pos <= LAST_POS)
    `DZ_ASSERT(a_count_plain, r_out_valid && r_out.field_kind == KIND_COUNT |-> !r_out.record_last && r_out.action_index == 6'd0)
    `DZ_ASSERT(a_done_parks, r_out_valid && r_out.stream_done |-> r_phase == PH_DONE)
    `DZ_ASSERT_NEXT(a_done_sticky, r_phase == PH_DONE, r_phase == PH_DONE)

endmodule

@@ hdl/delta_zigzag_varint_record_decoder.sv @@
// each value's beat is registered in the varint queue, then in the output register, after its final byte is accepted
// throughput: one byte per cycle while the varint queue is not full, set by the byte gatherer
// a two-entry varint queue lets the gatherer keep taking bytes while output stalls
// reset is synchronous, active low: decoder returns to reading the record count
// with key history, record count and partial varint cleared
`timescale 1ns / 1ps

module delta_zigzag_varint_record_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dzvr_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dzvr_pkg::t_out_beat o_out_data
);
    import dzvr_pkg::*;

    logic    w_push;
    t_varint w_push_data;
    logic    w_full;
    logic    w_q_valid;
    t_varint w_q_data;
    logic    w_pop;

    assign o_in_stall = w_full;

    dzvr_gather u_gather (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    dzvr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data)
    );

    dzvr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_data      (w_q_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ bench/dzvr_decode_check.sv @@
// watches both channels of the varint record decoder, predicts each result beat and compares
`timescale 1ns / 1ps

module dzvr_decode_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  dzvr_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  dzvr_pkg::t_out_beat i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import dzvr_pkg::*;

    typedef enum logic [2:0] {
        PH_COUNT    = 3'd0,
        PH_KEY      = 3'd1,
        PH_REGRET   = 3'd2,
        PH_STRATEGY = 3'd3,
        PH_DONE     = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_COUNT    = 2'd0;
    localparam logic [1:0] KIND_KEY      = 2'd1;
    localparam logic [1:0] KIND_REGRET   = 2'd2;
    localparam logic [1:0] KIND_STRATEGY = 2'd3;

    logic [63:0] gather_acc;
    logic [6:0]  gather_shift;
    t_phase      phase;
    logic [5:0]  slot;
    logic [63:0] records_todo;
    logic [63:0] running_key;
    t_out_beat   decoded_q[$];
    int          fails = 0;

    function automatic logic [63:0] from_zigzag(input logic [63:0] e);
        return (e >> 1) ^ (64'd0 - {63'd0, e[0]});
    endfunction

    task automatic decode_byte(input t_in_beat b);
        t_out_beat   res;
        logic [63:0] v;
        logic        stop;
        if (phase >= PH_DONE) begin
            return;
        end
        if (gather_shift < 7'd64) begin
            gather_acc |= {57'd0, b.in_byte[6:0]} << gather_shift;
        end
        if (b.in_byte[7] && !b.end_of_buffer) begin
            if (gather_shift < 7'd64) begin
                gather_shift += 7'd7;
            end
            return;
        end
        res = '0;
        res.truncated = b.in_byte[7];
        v = gather_acc;
        gather_acc = '0;
        gather_shift = '0;
        stop = 1'b0;
        case (phase)
            PH_COUNT: begin
                res.field_kind = KIND_COUNT;
                records_todo = v;
                if (v == 64'd0) begin
                    stop = 1'b1;
                end else begin
                    phase = PH_KEY;
                end
            end
            PH_KEY: begin
                res.field_kind = KIND_KEY;
                running_key += v;
                v = running_key;
                slot = '0;
                phase = PH_REGRET;
            end
            PH_REGRET: begin
                res.field_kind = KIND_REGRET;
                res.action_index = slot;
                v = from_zigzag(v);
                if (slot >= ACTIONS - 1) begin
                    slot = '0;
                    phase = PH_STRATEGY;
                end else begin
                    slot = slot + 6'd1;
                end
            end
            default: begin
                res.field_kind = KIND_STRATEGY;
                res.action_index = slot;
                v = from_zigzag(v);
                if (slot >= ACTIONS - 1) begin
                    slot = '0;
                    res.record_last = 1'b1;
                    records_todo -= 64'd1;
                    if (records_todo == 64'd0) begin
                        stop = 1'b1;
                    end else begin
                        phase = PH_KEY;
                    end
                end else begin
                    slot = slot + 6'd1;
                end
            end
        endcase
        // end of buffer closes the value, the record and the stream
        if (b.end_of_buffer) begin
            stop = 1'b1;
            if (res.field_kind != KIND_COUNT) begin
                res.record_last = 1'b1;
            end
        end
        if (stop) begin
            phase = PH_DONE;
        end
        res.value = v;
        res.stream_done = stop;
        decoded_q.insert(decoded_q.size(), res);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            gather_acc = '0;
            gather_shift = '0;
            phase = PH_COUNT;
            slot = '0;
            records_todo = '0;
            running_key = '0;
            decoded_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (decoded_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected beat: kind %0d idx %0d value %h last %0b trunc %0b done %0b",
                                 got.field_kind, got.action_index, got.value,
                                 got.record_last, got.truncated, got.stream_done);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (got.field_kind != want.field_kind
                            || got.action_index != want.action_index
                            || got.value != want.value
                            || got.record_last != want.record_last
                            || got.truncated != want.truncated
                            || got.stream_done != want.stream_done) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected kind %0d idx %0d value %h last %0b trunc %0b done %0b",
                                     want.field_kind, want.action_index, want.value,
                                     want.record_last, want.truncated, want.stream_done);
                            $display("          got      kind %0d idx %0d value %h last %0b trunc %0b done %0b",
                                     got.field_kind, got.action_index, got.value,
                                     got.record_last, got.truncated, got.stream_done);
                        end
                    end
                end
            end
        end
        o_pending <= decoded_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ bench/delta_zigzag_varint_record_decoder_test.sv @@
// stimulus and verdict for the varint record decoder, with the checker beside the block
`timescale 1ns / 1ps

module delta_zigzag_varint_record_decoder_test;
    import dzvr_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int BURST_BYTES   = 80;
    localparam int END_NATURAL   = 0;
    localparam int END_TRUNCATED = 1;
    localparam int END_CLEAN_EOB = 2;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    int        fail_count;
    int        pending;

    t_in_beat  byte_stream[$];
    bit        sender_calm = 1'b0;
    bit        receiver_calm = 1'b0;
    bit        hold_request = 1'b0;

    always #6 clk = ~clk;

    delta_zigzag_varint_record_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_beat)
    );

    dzvr_decode_check u_decode_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_beat),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // encodes one varint; pad adds redundant groups, junk fills groups above bit 63
    task automatic add_varint(input logic [63:0] v, input int pad, input bit junk,
                              input bit eob, input bit open_end);
        int         n;
        int         total;
        logic [6:0] grp;
        t_in_beat   b;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0) begin
            n++;
        end
        total = n + pad;
        for (int i = 0; i < total; i++) begin
            grp = (i < 10) ? 7'(v >> (7 * i)) : 7'd0;
            if (junk && i == 9) begin
                grp[6:1] = 6'($urandom);
            end
            if (junk && i > 9) begin
                grp = 7'($urandom);
            end
            b.in_byte = {(i != total - 1) || open_end, grp};
            b.end_of_buffer = (i == total - 1) && eob;
            byte_stream.insert(byte_stream.size(), b);
        end
    endtask

    function automatic logic [63:0] wide_random();
        int          nbits;
        logic [63:0] r;
        nbits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 20);
        r = {$urandom, $urandom};
        if (nbits < 64) begin
            r &= (64'd1 << nbits) - 64'd1;
        end
        return r;
    endfunction

    // first record: key wraps, zigzag extremes and varint length boundaries
    function automatic logic [63:0] directed_value(input int j);
        case (j)
            0:  return '1;
            1:  return 64'd0;
            2:  return 64'd1;
            3:  return 64'd2;
            4:  return '1;
            5:  return 64'hFFFF_FFFF_FFFF_FFFE;
            6:  return 64'd127;
            7:  return 64'd128;
            8:  return 64'h7FFF_FFFF_FFFF_FFFF;
            9:  return 64'h8000_0000_0000_0000;
            10: return 64'd16383;
            11: return 64'd16384;
            12: return 64'd0;
            13: return 64'h5555_5555_5555_5555;
            14: return 64'hAAAA_AAAA_AAAA_AAAA;
            15: return 64'd3;
            default: return 64'h0123_4567_89AB_CDEF;
        endcase
    endfunction

    // receiver: random stall per beat, calm stretches, one long hold-off
    initial begin : receive
        int wait_cycles;
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                receiver_calm = !receiver_calm;
            end
            if (hold_request) begin
                hold_request = 1'b0;
                wait_cycles = HOLD_CYCLES;
            end else begin
                wait_cycles = receiver_calm ? 0 : $urandom_range(0, 11);
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : send
        int          records;
        int          ending;
        int          cut_at;
        int          pad;
        bit          junk;
        logic [63:0] v;
        int          hold_at;
        int          pause_at;
        int          burst_left;
        int          gap;
        t_in_beat    noise;

        records = $urandom_range(14, 18);
        ending = $urandom_range(END_NATURAL, END_CLEAN_EOB);
        cut_at = $urandom_range(0, 2 * ACTIONS);
        add_varint(64'(records), $urandom_range(0, 1) * 10, 1'b1, 1'b0, 1'b0);
        for (int r = 0; r < records; r++) begin
            for (int j = 0; j <= 2 * ACTIONS; j++) begin
                v = (r == 0) ? directed_value(j) : wide_random();
                pad = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 4) : 0;
                junk = $urandom_range(0, 1);
                if (r == 1 && j == 0) begin
                    v = 64'd1;
                end
                if (r == 0 && j == 1) begin
                    pad = 2;
                end
                if (r == 0 && j == 12) begin
                    pad = 11;
                    junk = 1'b1;
                end
                if (r == records - 1 && ending != END_NATURAL && j == cut_at) begin
                    add_varint(v, pad, junk, 1'b1, ending == END_TRUNCATED);
                    break;
                end
                add_varint(v, pad, junk, 1'b0, 1'b0);
            end
        end
        // bytes past the end of the stream are ignored
        repeat ($urandom_range(4, 10)) begin
            noise.in_byte = 8'($urandom);
            noise.end_of_buffer = 1'($urandom);
            byte_stream.insert(byte_stream.size(), noise);
        end

        hold_at = byte_stream.size() / 3;
        pause_at = byte_stream.size() * 2 / 3;
        burst_left = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < byte_stream.size(); k++) begin
            if ($urandom_range(0, 39) == 0) begin
                sender_calm = !sender_calm;
            end
            if (k == hold_at) begin
                hold_request = 1'b1;
                burst_left = BURST_BYTES;
            end
            if (k == pause_at) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end else begin
                gap = (sender_calm || burst_left > 0) ? 0 : $urandom_range(0, 11);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            if (burst_left > 0) begin
                burst_left--;
            end
            in_valid <= 1'b1;
            in_beat <= byte_stream[k];
            do @(posedge clk); while (in_stall);
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("delta_zigzag_varint_record_decoder_test OK");
        end else begin
            $display("delta_zigzag_varint_record_decoder_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("delta_zigzag_varint_record_decoder_test NOT OK");
        $finish;
    end

endmodule
